[sv/sdci_pkg.sv]
// Package for the SD card init sequencer: item structs, sequencer state,
// command, response and failure codes. No dependencies.
package sdci_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_VOLT_WINDOW = 2'd0;
    localparam logic [1:0] CFG_BLOCK_LEN   = 2'd1;
    localparam logic [1:0] CFG_POLL_LIMIT  = 2'd2;

    // Input opcodes
    localparam logic OP_START    = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    // Command status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_CMD_TMO   = 3'd1;
    localparam logic [2:0] ST_DATA_TMO  = 3'd2;
    localparam logic [2:0] ST_CMD_CRC   = 3'd3;
    localparam logic [2:0] ST_DATA_CRC  = 3'd4;

    // Result actions
    localparam logic [1:0] ACT_ISSUE = 2'd0;
    localparam logic [1:0] ACT_DONE  = 2'd1;
    localparam logic [1:0] ACT_FAIL  = 2'd2;

    // Expected response kinds
    localparam logic [2:0] RSP_NONE = 3'd0;
    localparam logic [2:0] RSP_R1   = 3'd1;
    localparam logic [2:0] RSP_R1B  = 3'd2;
    localparam logic [2:0] RSP_R2   = 3'd3;
    localparam logic [2:0] RSP_R3   = 3'd4;
    localparam logic [2:0] RSP_R6   = 3'd5;

    // Failure reasons
    localparam logic [2:0] FR_NONE       = 3'd0;
    localparam logic [2:0] FR_NO_CMD8    = 3'd1;
    localparam logic [2:0] FR_CMD8_CHECK = 3'd2;
    localparam logic [2:0] FR_CMD8_ERR   = 3'd3;
    localparam logic [2:0] FR_NOT_SD     = 3'd4;
    localparam logic [2:0] FR_ACMD41_ERR = 3'd5;
    localparam logic [2:0] FR_NEVER_RDY  = 3'd6;
    localparam logic [2:0] FR_NO_CID     = 3'd7;

    // Command indexes
    localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
    localparam logic [5:0] CMD_ALL_CID  = 6'd2;
    localparam logic [5:0] CMD_SEND_RCA = 6'd3;
    localparam logic [5:0] CMD_BUS_WID  = 6'd6;
    localparam logic [5:0] CMD_SELECT   = 6'd7;
    localparam logic [5:0] CMD_IF_COND  = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD = 6'd9;
    localparam logic [5:0] CMD_STATUS   = 6'd13;
    localparam logic [5:0] CMD_BLOCKLEN = 6'd16;
    localparam logic [5:0] CMD_OP_COND  = 6'd41;
    localparam logic [5:0] CMD_APP      = 6'd55;

    localparam logic [31:0] CHECK_ARG = 32'h0000_01AA;
    localparam logic [31:0] BUS_4BIT  = 32'd2;

    // CSD as received, without the CRC byte (CSD bits 127..8)
    localparam int CSD_W = 120;

    typedef enum logic [16:0] {
        PH_IDLE   = 17'b0_0000_0000_0000_0001,
        PH_CMD0   = 17'b0_0000_0000_0000_0010,
        PH_CMD8   = 17'b0_0000_0000_0000_0100,
        PH_INQ55  = 17'b0_0000_0000_0000_1000,
        PH_INQ41  = 17'b0_0000_0000_0001_0000,
        PH_POLL55 = 17'b0_0000_0000_0010_0000,
        PH_POLL41 = 17'b0_0000_0000_0100_0000,
        PH_CID    = 17'b0_0000_0000_1000_0000,
        PH_RCA    = 17'b0_0000_0001_0000_0000,
        PH_CSD    = 17'b0_0000_0010_0000_0000,
        PH_STAT   = 17'b0_0000_0100_0000_0000,
        PH_SEL    = 17'b0_0000_1000_0000_0000,
        PH_BUS55  = 17'b0_0001_0000_0000_0000,
        PH_BUS6   = 17'b0_0010_0000_0000_0000,
        PH_BLEN   = 17'b0_0100_0000_0000_0000,
        PH_DONE   = 17'b0_1000_0000_0000_0000,
        PH_FAIL   = 17'b1_0000_0000_0000_0000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  poll_count;
        logic [15:0] rca;
        logic        ccs;
    } t_seq_state;

    typedef struct packed {
        logic [31:0] volt_window;
        logic [11:0] block_len;
        logic [7:0]  poll_limit;
    } t_cfg;

    typedef struct packed {
        logic        op;
        logic [2:0]  cmd_status;
        logic [31:0] resp_word0;
        logic [31:0] resp_word1;
        logic [31:0] resp_word2;
        logic [31:0] resp_word3;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  cmd_index;
        logic [31:0] cmd_arg;
        logic [2:0]  rsp_kind;
        logic [2:0]  fail_reason;
        logic        is_high_capacity;
        logic [15:0] card_addr;
        logic [42:0] capacity_bytes;
        logic        capacity_valid;
    } t_out_item;

endpackage

[sv/sdci_cap.sv]
// Capacity decode from the stored CSD register (structure versions 1 and 2).
// Depends on sdci_pkg.
module sdci_cap (
    input  logic [sdci_pkg::CSD_W-1:0] i_csd,
    output logic [42:0]                o_cap_bytes,
    output logic                       o_cap_valid
);
    import sdci_pkg::*;

    // i_csd bit k holds CSD bit k+8
    logic [1:0]  csd_struct;
    logic [12:0] v1_size;
    logic [3:0]  v1_shift;
    logic [3:0]  v1_bl;
    logic [22:0] v2_size;
    logic [42:0] v1_cap;
    logic [42:0] v2_cap;

    always_comb begin
        csd_struct = i_csd[119:118];
        v1_size    = {1'b0, i_csd[65:54]} + 13'd1;
        v1_shift   = {1'b0, i_csd[41:39]} + 4'd2;
        v1_bl      = i_csd[75:72];
        v2_size    = {1'b0, i_csd[61:40]} + 23'd1;
        v1_cap     = (43'(v1_size) << v1_shift) << v1_bl;
        // size times 512 KiB
        v2_cap     = 43'(v2_size) << 19;
        unique case (csd_struct)
            2'd0: begin
                o_cap_bytes = v1_cap;
                o_cap_valid = 1'b1;
            end
            2'd1: begin
                o_cap_bytes = v2_cap;
                o_cap_valid = 1'b1;
            end
            default: begin
                o_cap_bytes = '0;
                o_cap_valid = 1'b0;
            end
        endcase
    end
endmodule

[sv/sdci_step.sv]
// Decision logic of the init sequencer: next phase, stored card data and the
// result item for one input item. Depends on sdci_pkg.
module sdci_step (
    input  sdci_pkg::t_seq_state i_state,
    input  sdci_pkg::t_cfg       i_cfg,
    input  sdci_pkg::t_in_item   i_item,
    input  logic [42:0]          i_cap_bytes,
    input  logic                 i_cap_valid,
    output sdci_pkg::t_seq_state o_state,
    output logic                 o_emit,
    output logic                 o_csd_we,
    output sdci_pkg::t_out_item  o_result
);
    import sdci_pkg::*;

    logic [31:0] w0;
    logic [2:0]  st;
    logic [31:0] rarg;
    logic [7:0]  poll_inc;
    logic [1:0]  act;
    logic [5:0]  idx;
    logic [31:0] arg;
    logic [2:0]  rsp;
    logic [2:0]  reason;

    always_comb begin
        w0       = i_item.resp_word0;
        st       = i_item.cmd_status;
        rarg     = {i_state.rca, 16'h0000};
        poll_inc = (i_state.poll_count == 8'hFF) ? 8'hFF : i_state.poll_count + 8'd1;

        o_state  = i_state;
        o_emit   = 1'b1;
        o_csd_we = 1'b0;
        act      = ACT_ISSUE;
        idx      = CMD_GO_IDLE;
        arg      = '0;
        rsp      = RSP_NONE;
        reason   = FR_NONE;

        if (i_item.op == OP_START) begin
            o_state.phase      = PH_CMD0;
            o_state.poll_count = '0;
            o_state.rca        = '0;
            o_state.ccs        = 1'b0;
        end else begin
            unique case (i_state.phase)
                PH_CMD0: begin
                    o_state.phase = PH_CMD8;
                    idx = CMD_IF_COND;
                    arg = CHECK_ARG;
                    rsp = RSP_R1;
                end
                PH_CMD8: begin
                    priority if (st == ST_CMD_TMO || st == ST_DATA_TMO) begin
                        act    = ACT_FAIL;
                        reason = FR_NO_CMD8;
                    end else if (st == ST_CMD_CRC || st == ST_DATA_CRC
                                 || w0[11:8] != CHECK_ARG[11:8]
                                 || w0[7:0] != CHECK_ARG[7:0]) begin
                        act    = ACT_FAIL;
                        reason = FR_CMD8_CHECK;
                    end else if (st != ST_OK) begin
                        act    = ACT_FAIL;
                        reason = FR_CMD8_ERR;
                    end else begin
                        o_state.phase = PH_INQ55;
                        idx = CMD_APP;
                        rsp = RSP_R1;
                    end
                end
                PH_INQ55: begin
                    if (st != ST_OK) begin
                        act    = ACT_FAIL;
                        reason = FR_NOT_SD;
                    end else begin
                        o_state.phase = PH_INQ41;
                        idx = CMD_OP_COND;
                        rsp = RSP_R3;
                    end
                end
                PH_INQ41: begin
                    if (st != ST_OK) begin
                        act    = ACT_FAIL;
                        reason = FR_ACMD41_ERR;
                    end else begin
                        o_state.phase      = PH_POLL55;
                        o_state.poll_count = '0;
                        idx = CMD_APP;
                        rsp = RSP_R1;
                    end
                end
                PH_POLL55: begin
                    o_state.phase = PH_POLL41;
                    idx = CMD_OP_COND;
                    arg = i_cfg.volt_window;
                    rsp = RSP_R3;
                end
                PH_POLL41: begin
                    o_state.poll_count = poll_inc;
                    // ready wins even on the last allowed poll
                    priority if (w0[31]) begin
                        o_state.ccs   = w0[30];
                        o_state.phase = PH_CID;
                        idx = CMD_ALL_CID;
                        rsp = RSP_R2;
                    end else if (poll_inc >= i_cfg.poll_limit) begin
                        act    = ACT_FAIL;
                        reason = FR_NEVER_RDY;
                    end else begin
                        o_state.phase = PH_POLL55;
                        idx = CMD_APP;
                        rsp = RSP_R1;
                    end
                end
                PH_CID: begin
                    if (st != ST_OK) begin
                        act    = ACT_FAIL;
                        reason = FR_NO_CID;
                    end else begin
                        o_state.phase = PH_RCA;
                        idx = CMD_SEND_RCA;
                        rsp = RSP_R6;
                    end
                end
                PH_RCA: begin
                    o_state.rca   = w0[31:16];
                    o_state.phase = PH_CSD;
                    idx = CMD_SEND_CSD;
                    arg = {w0[31:16], 16'h0000};
                    rsp = RSP_R2;
                end
                PH_CSD: begin
                    o_csd_we      = 1'b1;
                    o_state.phase = PH_STAT;
                    idx = CMD_STATUS;
                    arg = rarg;
                    rsp = RSP_R1;
                end
                PH_STAT: begin
                    o_state.phase = PH_SEL;
                    idx = CMD_SELECT;
                    arg = rarg;
                    rsp = RSP_R1B;
                end
                PH_SEL: begin
                    o_state.phase = PH_BUS55;
                    idx = CMD_APP;
                    arg = rarg;
                    rsp = RSP_R1;
                end
                PH_BUS55: begin
                    o_state.phase = PH_BUS6;
                    idx = CMD_BUS_WID;
                    arg = BUS_4BIT;
                    rsp = RSP_R1;
                end
                PH_BUS6: begin
                    if (!i_state.ccs) begin
                        o_state.phase = PH_BLEN;
                        idx = CMD_BLOCKLEN;
                        arg = 32'(i_cfg.block_len);
                        rsp = RSP_R1;
                    end else begin
                        act = ACT_DONE;
                    end
                end
                PH_BLEN: begin
                    act = ACT_DONE;
                end
                default: begin
                    // idle, done or failed: nothing outstanding, drop the item
                    o_emit = 1'b0;
                end
            endcase
            if (act == ACT_FAIL) begin
                o_state.phase = PH_FAIL;
            end else if (act == ACT_DONE) begin
                o_state.phase = PH_DONE;
            end
        end

        o_result.action           = act;
        o_result.cmd_index        = idx;
        o_result.cmd_arg          = arg;
        o_result.rsp_kind         = rsp;
        o_result.fail_reason      = reason;
        o_result.is_high_capacity = o_state.ccs;
        o_result.card_addr        = o_state.rca;
        o_result.capacity_bytes   = (act == ACT_DONE) ? i_cap_bytes : '0;
        o_result.capacity_valid   = (act == ACT_DONE) ? i_cap_valid : 1'b0;
    end
endmodule

[sv/sd_card_init_sequencer.sv]
// SD card init sequencer top level: input register, sequencer state, CSD
// store and result register. Depends on sdci_pkg, sdci_step and sdci_cap.
//
// Use: send a start item (op 0) to begin; after that, send one completion
// item (op 1) with status and response words for each command issued. Each
// item that has something outstanding yields one result item: the next
// command with its argument and expected response, done with the decoded
// card capacity, or failed with a reason. A completion while idle, done or
// failed yields nothing. A start at any time restarts from CMD0.
// Channels use valid/stall; an item moves when valid is high and stall low.
// An accepted item waits in the input register while the decision logic loads
// the result register; the result is then offered from the result register.
// Throughput is one item per cycle while the receiver does not stall, set by
// the single decision stage.
// When the receiver stalls, the result register holds and the input stall
// rises once the input register is also full.
// Reset clears phase to idle, card address, capacity flag, poll count and
// loads the configuration defaults; the CSD store is not reset.
// Configuration writes are taken any cycle the write enable is high.
module sd_card_init_sequencer #(
    parameter logic [31:0] VOLT_WINDOW_RST = 32'h4000_0000,
    parameter logic [11:0] BLOCK_LEN_RST   = 12'd512,
    parameter logic [7:0]  POLL_LIMIT_RST  = 8'd12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sdci_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sdci_pkg::t_out_item o_out_item
);
    import sdci_pkg::*;

    t_cfg                r_cfg;
    t_seq_state          r_state;
    t_seq_state          n_state;
    logic                r_in_valid;
    t_in_item            r_in;
    logic                r_out_valid;
    t_out_item           r_out;
    t_out_item           n_out;
    logic [CSD_W-1:0]    r_csd;
    logic                step_emit;
    logic                csd_we;
    logic                advance;
    logic [42:0]         cap_bytes;
    logic                cap_valid;

    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;

    sdci_cap u_cap (
        .i_csd       (r_csd),
        .o_cap_bytes (cap_bytes),
        .o_cap_valid (cap_valid)
    );

    sdci_step u_step (
        .i_state     (r_state),
        .i_cfg       (r_cfg),
        .i_item      (r_in),
        .i_cap_bytes (cap_bytes),
        .i_cap_valid (cap_valid),
        .o_state     (n_state),
        .o_emit      (step_emit),
        .o_csd_we    (csd_we),
        .o_result    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.volt_window <= VOLT_WINDOW_RST;
            r_cfg.block_len   <= BLOCK_LEN_RST;
            r_cfg.poll_limit  <= POLL_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VOLT_WINDOW: r_cfg.volt_window <= i_cfg_data;
                CFG_BLOCK_LEN:   r_cfg.block_len   <= i_cfg_data[11:0];
                CFG_POLL_LIMIT:  r_cfg.poll_limit  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= PH_IDLE;
            r_state.poll_count <= '0;
            r_state.rca        <= '0;
            r_state.ccs        <= 1'b0;
            r_out_valid        <= 1'b0;
        end else if (r_in_valid && advance) begin
            r_state     <= n_state;
            r_out_valid <= step_emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the stored CSD without the CRC byte, and load the result register
    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance && csd_we) begin
            r_csd <= {r_in.resp_word3[23:0], r_in.resp_word2,
                      r_in.resp_word1, r_in.resp_word0};
        end
        if (r_in_valid && advance && step_emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef ASSERT_OFF
    a_start_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && r_in.op == OP_START)
        |=> (r_state.phase == PH_CMD0 && r_state.poll_count == 8'd0
             && r_state.rca == 16'd0 && o_out_valid))
        else $error("start item did not restart the sequence");

    a_idle_cmd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.action != ACT_ISSUE)
        |-> (o_out_item.cmd_index == 6'd0 && o_out_item.cmd_arg == 32'd0
             && o_out_item.rsp_kind == RSP_NONE))
        else $error("command fields set on a non-issue result");

    a_reason_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.fail_reason != FR_NONE)
                         == (o_out_item.action == ACT_FAIL)))
        else $error("fail reason does not match action");

    a_cap_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.capacity_valid) |-> (o_out_item.action == ACT_DONE))
        else $error("capacity reported without done");

    a_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && step_emit && n_out.action == ACT_DONE)
        |=> (r_state.phase == PH_DONE))
        else $error("done result without done phase");
`endif
endmodule

[verif/tb_sd_card_init_sequencer.sv]
// Self-checking testbench for sd_card_init_sequencer: random card sessions
// are driven against an in-bench model of the command sequence and scored.
// Depends on sdci_pkg and the sd_card_init_sequencer RTL.
module tb_sd_card_init_sequencer;
    import sdci_pkg::*;

    localparam int LONG_HOLD         = 250;
    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int SETTLE_CYCLES     = 4;
    localparam int ITEMS_PER_SETTING = 240;
    localparam int NUM_SETTINGS      = 6;
    localparam int OCR_READY         = 31;
    localparam int OCR_CCS           = 30;
    localparam logic [63:0] CSD2_UNIT = 64'd512 * 64'd1024;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [1:0]  cfg_idx    = '0;
    logic [31:0] cfg_data   = '0;
    logic        in_valid   = 1'b0;
    t_in_item    in_item    = '0;
    logic        out_stall  = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_item;

    // Model of the sequencer and its registers
    t_phase       seq_phase = PH_IDLE;
    logic [7:0]   seq_polls = '0;
    logic [15:0]  seq_rca   = '0;
    logic         seq_ccs   = 1'b0;
    logic [127:0] seq_csd   = '0;
    logic [31:0]  cfg_volt  = 32'h4000_0000;
    logic [11:0]  cfg_blen  = 12'd512;
    logic [7:0]   cfg_limit = 8'd12;

    t_in_item  card_events[$];
    t_out_item expected_replies[$];
    int        queued_items   = 0;
    int        mismatch_count = 0;
    logic      in_taken       = 1'b0;
    int        burst_left     = 0;
    int        gap_left       = 0;
    bit        long_hold_go   = 1'b0;
    bit        long_hold_done = 1'b0;
    int        hold_left      = 0;
    int        stall_mode     = 0;
    int        mode_left      = 0;
    int        quiet_cycles   = 0;

    sd_card_init_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_out_item make_reply(logic [1:0] act, logic [5:0] idx,
                                             logic [31:0] arg, logic [2:0] rsp,
                                             logic [2:0] why);
        t_out_item   r;
        logic [63:0] blocks;
        int          shift;
        r = '0;
        r.action           = act;
        r.cmd_index        = idx;
        r.cmd_arg          = arg;
        r.rsp_kind         = rsp;
        r.fail_reason      = why;
        r.is_high_capacity = seq_ccs;
        r.card_addr        = seq_rca;
        if (act == ACT_DONE) begin
            blocks = '0;
            if (seq_csd[127:126] == 2'd0) begin
                // v1: (device size + 1) << (size multiplier + 2) << block size exponent
                blocks[11:0] = seq_csd[73:62];
                shift = seq_csd[49:47] + 2 + seq_csd[83:80];
                blocks = (blocks + 64'd1) << shift;
                r.capacity_bytes = blocks[42:0];
                r.capacity_valid = 1'b1;
            end else if (seq_csd[127:126] == 2'd1) begin
                blocks[21:0] = seq_csd[69:48];
                blocks = (blocks + 64'd1) * CSD2_UNIT;
                r.capacity_bytes = blocks[42:0];
                r.capacity_valid = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic predict_next_command(input t_in_item it, output bit answers,
                                        output t_out_item reply);
        t_phase      nxt;
        logic [1:0]  act;
        logic [5:0]  idx;
        logic [31:0] arg;
        logic [2:0]  rsp;
        logic [2:0]  why;
        logic [31:0] sel_arg;
        sel_arg = {seq_rca, 16'h0000};
        answers = 1'b1;
        act = ACT_ISSUE;
        idx = CMD_GO_IDLE;
        arg = '0;
        rsp = RSP_NONE;
        why = FR_NONE;
        nxt = seq_phase;
        if (it.op == OP_START) begin
            seq_polls = '0;
            seq_rca   = '0;
            seq_ccs   = 1'b0;
            nxt = PH_CMD0;
        end else begin
            case (seq_phase)
                PH_CMD0: begin
                    nxt = PH_CMD8; idx = CMD_IF_COND; arg = CHECK_ARG; rsp = RSP_R1;
                end
                PH_CMD8: begin
                    if (it.cmd_status == ST_CMD_TMO || it.cmd_status == ST_DATA_TMO) begin
                        why = FR_NO_CMD8;
                    end else if (it.cmd_status == ST_CMD_CRC || it.cmd_status == ST_DATA_CRC
                                 || it.resp_word0[11:8] != CHECK_ARG[11:8]
                                 || it.resp_word0[7:0] != CHECK_ARG[7:0]) begin
                        why = FR_CMD8_CHECK;
                    end else if (it.cmd_status != ST_OK) begin
                        why = FR_CMD8_ERR;
                    end else begin
                        nxt = PH_INQ55; idx = CMD_APP; rsp = RSP_R1;
                    end
                end
                PH_INQ55: begin
                    if (it.cmd_status != ST_OK) why = FR_NOT_SD;
                    else begin
                        nxt = PH_INQ41; idx = CMD_OP_COND; rsp = RSP_R3;
                    end
                end
                PH_INQ41: begin
                    if (it.cmd_status != ST_OK) why = FR_ACMD41_ERR;
                    else begin
                        seq_polls = '0;
                        nxt = PH_POLL55; idx = CMD_APP; rsp = RSP_R1;
                    end
                end
                PH_POLL55: begin
                    nxt = PH_POLL41; idx = CMD_OP_COND; arg = cfg_volt; rsp = RSP_R3;
                end
                PH_POLL41: begin
                    if (seq_polls != 8'hFF) seq_polls = seq_polls + 8'd1;
                    if (it.resp_word0[OCR_READY]) begin
                        seq_ccs = it.resp_word0[OCR_CCS];
                        nxt = PH_CID; idx = CMD_ALL_CID; rsp = RSP_R2;
                    end else if (seq_polls >= cfg_limit) begin
                        why = FR_NEVER_RDY;
                    end else begin
                        nxt = PH_POLL55; idx = CMD_APP; rsp = RSP_R1;
                    end
                end
                PH_CID: begin
                    if (it.cmd_status != ST_OK) why = FR_NO_CID;
                    else begin
                        nxt = PH_RCA; idx = CMD_SEND_RCA; rsp = RSP_R6;
                    end
                end
                PH_RCA: begin
                    seq_rca = it.resp_word0[31:16];
                    nxt = PH_CSD; idx = CMD_SEND_CSD; arg = {seq_rca, 16'h0000}; rsp = RSP_R2;
                end
                PH_CSD: begin
                    // the controller drops the CRC byte, so the CSD sits 8 bits up
                    seq_csd = {it.resp_word3[23:0], it.resp_word2, it.resp_word1,
                               it.resp_word0, 8'h00};
                    nxt = PH_STAT; idx = CMD_STATUS; arg = sel_arg; rsp = RSP_R1;
                end
                PH_STAT: begin
                    nxt = PH_SEL; idx = CMD_SELECT; arg = sel_arg; rsp = RSP_R1B;
                end
                PH_SEL: begin
                    nxt = PH_BUS55; idx = CMD_APP; arg = sel_arg; rsp = RSP_R1;
                end
                PH_BUS55: begin
                    nxt = PH_BUS6; idx = CMD_BUS_WID; arg = BUS_4BIT; rsp = RSP_R1;
                end
                PH_BUS6: begin
                    if (!seq_ccs) begin
                        nxt = PH_BLEN; idx = CMD_BLOCKLEN; arg = {20'h0, cfg_blen}; rsp = RSP_R1;
                    end else begin
                        nxt = PH_DONE; act = ACT_DONE;
                    end
                end
                PH_BLEN: begin
                    nxt = PH_DONE; act = ACT_DONE;
                end
                default: answers = 1'b0;
            endcase
        end
        if (why != FR_NONE) begin
            nxt = PH_FAIL;
            act = ACT_FAIL;
        end
        seq_phase = nxt;
        reply = make_reply(act, idx, arg, rsp, why);
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endfunction

    // Accept, predict and score at the rising edge
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item reply;
        bit        answers;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_valid && !o_in_stall;
            if (in_valid && !o_in_stall) begin
                predict_next_command(in_item, answers, reply);
                if (answers) expected_replies.push_back(reply);
            end
            if (o_out_valid && !out_stall) begin
                if (expected_replies.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result item %h with nothing expected", $time, o_out_item);
                end else begin
                    want = expected_replies.pop_front();
                    check_field("action", want.action, o_out_item.action);
                    check_field("cmd_index", want.cmd_index, o_out_item.cmd_index);
                    check_field("cmd_arg", want.cmd_arg, o_out_item.cmd_arg);
                    check_field("rsp_kind", want.rsp_kind, o_out_item.rsp_kind);
                    check_field("fail_reason", want.fail_reason, o_out_item.fail_reason);
                    check_field("is_high_capacity", want.is_high_capacity,
                                o_out_item.is_high_capacity);
                    check_field("card_addr", want.card_addr, o_out_item.card_addr);
                    check_field("capacity_bytes", want.capacity_bytes,
                                o_out_item.capacity_bytes);
                    check_field("capacity_valid", want.capacity_valid,
                                o_out_item.capacity_valid);
                end
            end
        end
    end

    // Sender: bursts of items with random gaps in between
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_valid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (card_events.size() > 0) begin
                in_item  <= card_events.pop_front();
                in_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall modes that change now and then, plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (long_hold_go && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
            out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(10, 80);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) || cfg_we || !i_rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic void add_card_item(logic op, logic [2:0] st, logic [31:0] w0,
                                          logic [31:0] w1, logic [31:0] w2, logic [31:0] w3);
        t_in_item it;
        it.op         = op;
        it.cmd_status = st;
        it.resp_word0 = w0;
        it.resp_word1 = w1;
        it.resp_word2 = w2;
        it.resp_word3 = w3;
        card_events.push_back(it);
        queued_items++;
    endfunction

    function automatic void add_completion(logic [2:0] st, logic [31:0] w0);
        add_card_item(OP_COMPLETE, st, w0, $urandom, $urandom, $urandom);
    endfunction

    // status on steps where the sequencer ignores it
    function automatic logic [2:0] loose_status();
        if ($urandom_range(0, 1) == 0) return ST_OK;
        return 3'($urandom_range(1, 7));
    endfunction

    // status on checked steps: mostly good so sessions get deep
    function automatic logic [2:0] checked_status();
        if ($urandom_range(0, 24) != 0) return ST_OK;
        return 3'($urandom_range(1, 7));
    endfunction

    function automatic bit cut_short();
        return $urandom_range(0, 49) == 0;
    endfunction

    // One card bring-up from start, random content, occasional failures
    task automatic queue_session();
        logic [31:0] w0;
        logic [31:0] w3;
        logic [2:0]  st;
        int          pick;
        int          polls;
        int          max_polls;
        bit          ready_end;
        bit          high_cap;
        add_card_item(OP_START, 3'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
                      $urandom);
        add_completion(loose_status(), $urandom);
        if (cut_short()) return;
        w0 = $urandom;
        w0[11:0] = CHECK_ARG[11:0];
        pick = $urandom_range(0, 19);
        st = (pick == 0) ? 3'($urandom_range(1, 7)) : ST_OK;
        if (pick == 1) w0[$urandom_range(0, 11)] = ~w0[$urandom_range(0, 11)];
        if (pick == 1 && w0[11:0] == CHECK_ARG[11:0]) w0[0] = ~w0[0];
        add_completion(st, w0);
        if (pick < 2) return;
        st = checked_status();
        add_completion(st, $urandom);
        if (st != ST_OK) return;
        st = checked_status();
        add_completion(st, $urandom);
        if (st != ST_OK) return;
        max_polls = (cfg_limit == 0) ? 1 : cfg_limit;
        pick = $urandom_range(0, 9);
        ready_end = 1'b1;
        polls = $urandom_range(1, 3);
        if (max_polls <= 16 && pick < 2) begin
            polls = max_polls;
            ready_end = (pick == 0);
        end else if (polls > max_polls) begin
            polls = max_polls;
        end
        high_cap = 1'b0;
        for (int i = 1; i <= polls; i++) begin
            add_completion(loose_status(), $urandom);
            w0 = $urandom;
            w0[OCR_READY] = (i == polls) && ready_end;
            high_cap = w0[OCR_CCS];
            add_completion(loose_status(), w0);
        end
        if (!ready_end) return;
        st = checked_status();
        add_completion(st, $urandom);
        if (st != ST_OK) return;
        add_completion(loose_status(), $urandom);
        w3 = $urandom;
        pick = $urandom_range(0, 9);
        w3[23:22] = (pick < 4) ? 2'd0 : (pick < 8) ? 2'd1 : 2'(pick - 6);
        add_card_item(OP_COMPLETE, loose_status(), $urandom, $urandom, $urandom, w3);
        if (cut_short()) return;
        repeat (4) add_completion(loose_status(), $urandom);
        // standard capacity needs CMD16; otherwise a stray completion after done
        if (!high_cap || $urandom_range(0, 3) == 0) add_completion(loose_status(), $urandom);
    endtask

    task automatic wait_for_idle();
        while (card_events.size() != 0 || in_valid || expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_settings(logic [31:0] volt, logic [11:0] blen, logic [7:0] limit);
        wait_for_idle();
        @(negedge i_clk);
        cfg_we <= 1'b1; cfg_idx <= CFG_VOLT_WINDOW; cfg_data <= volt;
        @(negedge i_clk);
        cfg_idx <= CFG_BLOCK_LEN; cfg_data <= {20'h0, blen};
        @(negedge i_clk);
        cfg_idx <= CFG_POLL_LIMIT; cfg_data <= {24'h0, limit};
        @(negedge i_clk);
        cfg_we <= 1'b0;
        cfg_volt  = volt;
        cfg_blen  = blen;
        cfg_limit = limit;
        @(posedge i_clk);
    endtask

    initial begin
        int goal;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // completion with nothing outstanding, then CMD8 failure flavors
        add_card_item(OP_COMPLETE, 3'd7, '1, '1, '1, '1);
        add_card_item(OP_START, ST_OK, '0, '0, '0, '0);
        add_card_item(OP_COMPLETE, 3'd7, '1, '1, '1, '1);
        add_card_item(OP_COMPLETE, ST_CMD_TMO, CHECK_ARG, '0, '0, '0);
        add_card_item(OP_COMPLETE, ST_OK, '0, '0, '0, '0);
        add_card_item(OP_START, 3'd7, '1, '1, '1, '1);
        add_completion(ST_OK, '0);
        add_completion(ST_DATA_CRC, CHECK_ARG);
        add_card_item(OP_START, ST_OK, '0, '0, '0, '0);
        add_completion(ST_OK, '0);
        add_completion(3'd5, CHECK_ARG);
        // restart while busy, a bad voltage-accepted nibble, then CMD55 and ACMD41 failures
        add_card_item(OP_START, ST_OK, '0, '0, '0, '0);
        add_card_item(OP_START, ST_OK, '0, '0, '0, '0);
        add_completion(ST_OK, '0);
        add_completion(ST_OK, 32'h0000_02AA);
        add_card_item(OP_START, ST_OK, '0, '0, '0, '0);
        add_completion(ST_OK, '0);
        add_completion(ST_OK, 32'hFFFF_F1AA);
        add_completion(ST_CMD_TMO, '1);
        add_card_item(OP_START, ST_OK, '0, '0, '0, '0);
        add_completion(ST_OK, '0);
        add_completion(ST_OK, CHECK_ARG);
        add_completion(ST_OK, '0);
        add_completion(ST_CMD_CRC, '1);

        for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
            case (setting)
                0:       ;
                1:       apply_settings(32'hFFFF_FFFF, 12'd2048, 8'd255);
                2:       apply_settings(32'h0000_0000, 12'd1, 8'd1);
                3:       apply_settings($urandom, 12'($urandom_range(1, 2048)), 8'd0);
                4:       apply_settings($urandom, 12'($urandom_range(1, 2048)),
                                        8'($urandom_range(1, 255)));
                default: apply_settings($urandom, 12'($urandom_range(1, 2048)),
                                        8'($urandom_range(1, 6)));
            endcase
            goal = queued_items + ITEMS_PER_SETTING;
            while (queued_items < goal) begin
                if ($urandom_range(0, 19) == 0) begin
                    repeat ($urandom_range(1, 3))
                        add_card_item(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                                      $urandom, $urandom, $urandom, $urandom);
                end
                queue_session();
            end
            if (setting == 0) long_hold_go = 1'b1;
        end

        wait_for_idle();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[sd_card_init_sequencer.f]
sv/sdci_pkg.sv
sv/sdci_cap.sv
sv/sdci_step.sv
sv/sd_card_init_sequencer.sv
verif/tb_sd_card_init_sequencer.sv
